// ===== sv/srt_pkg.sv =====
// Shared types and constants for the stripe range table.
// Used by srt_ctrl, srt_dpath and stripe_range_table; no dependencies.
package srt_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int POS_W       = 64;
   localparam int EP_W        = 64;
   localparam int WID_W       = 16;
   localparam int ST_W        = 3;

   typedef enum logic [1:0] {
      REQ_ADD,
      REQ_CLONE,
      REQ_FIND,
      REQ_LATEST
   } req_code_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK,
      ST_EMPTY,
      ST_NOT_AFTER,
      ST_ZERO_WIDTH,
      ST_FULL,
      ST_BELOW
   } status_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [EP_W-1:0]  ep;
      logic [WID_W-1:0] wid;
   } entry_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic rd_loop;
      logic compare;
      logic capture;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_search;
      logic search_more;
   } sts_type;

endpackage

// ===== sv/srt_ctrl.sv =====
// Controller state machine for the stripe range table.
// Depends on srt_pkg; drives srt_dpath by command struct.
module srt_ctrl
   import srt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_LOOP,
      S_COMPARE,
      S_CAPTURE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.need_search ? S_LOOP : S_DONE;
         end
         S_LOOP: begin
            cmd.rd_loop = 1'b1;
            state_in    = sts.search_more ? S_COMPARE : S_CAPTURE;
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_LOOP;
         end
         S_CAPTURE: begin
            cmd.capture = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/srt_dpath.sv =====
// Datapath for the stripe range table: entry memory, latest-entry registers,
// binary search bounds and result registers. Depends on srt_pkg.
module srt_dpath
   import srt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic [1:0]       req_type,
   input  logic [POS_W-1:0] req_position,
   input  logic [EP_W-1:0]  req_epoch,
   input  logic [WID_W-1:0] req_stripe_width,
   output logic [ST_W-1:0]  rsp_status,
   output logic [POS_W-1:0] rsp_entry_position,
   output logic [EP_W-1:0]  rsp_entry_epoch,
   output logic [WID_W-1:0] rsp_entry_width
);

   entry_type        mem [MAX_ENTRIES];
   entry_type        rd_data_ff;
   logic [IDX_W-1:0] rd_addr;

   req_code_type     q_type_ff;
   logic [POS_W-1:0] q_pos_ff;
   logic [EP_W-1:0]  q_ep_ff;
   logic [WID_W-1:0] q_w_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   entry_type        last_ff;
   logic [POS_W-1:0] first_pos_ff;
   logic [CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid, lo_m1;

   status_type       res_st_ff, res_st_in, out_st_ff;
   entry_type        res_ent_ff, res_ent_in, out_ent_ff;

   status_type       dec_st;
   entry_type        dec_ent, wr_ent;
   logic             wr_en, need_search, empty, full;
   logic [POS_W-1:0] clone_pos;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(MAX_ENTRIES));
   assign clone_pos = (q_pos_ff == '0) ? last_ff.pos + POS_W'(1) : q_pos_ff;

   always_comb begin
      dec_st      = ST_OK;
      wr_en       = 1'b0;
      need_search = 1'b0;
      wr_ent      = '{pos: q_pos_ff, ep: q_ep_ff, wid: q_w_ff};
      case (q_type_ff)
         REQ_ADD: begin
            if (!empty && q_pos_ff <= last_ff.pos) dec_st = ST_NOT_AFTER;
            else if (q_w_ff == '0)                 dec_st = ST_ZERO_WIDTH;
            else if (full)                         dec_st = ST_FULL;
            else                                   wr_en  = 1'b1;
         end
         REQ_CLONE: begin
            wr_ent = '{pos: clone_pos, ep: q_ep_ff, wid: last_ff.wid};
            if (empty)                             dec_st = ST_EMPTY;
            else if (clone_pos <= last_ff.pos)     dec_st = ST_NOT_AFTER;
            else if (full)                         dec_st = ST_FULL;
            else                                   wr_en  = 1'b1;
         end
         REQ_FIND: begin
            if (empty)                             dec_st      = ST_EMPTY;
            else if (q_pos_ff < first_pos_ff)      dec_st      = ST_BELOW;
            else                                   need_search = 1'b1;
         end
         REQ_LATEST: begin
            if (empty)                             dec_st = ST_EMPTY;
         end
         default: dec_st = ST_OK;
      endcase
      if (dec_st != ST_OK) dec_ent = '0;
      else if (wr_en)      dec_ent = wr_ent;
      else                 dec_ent = last_ff;
   end

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_m1   = lo_ff - CNT_W'(1);
   assign rd_addr = (lo_ff < hi_ff) ? mid[IDX_W-1:0] : lo_m1[IDX_W-1:0];

   assign sts.need_search = need_search;
   assign sts.search_more = (lo_ff < hi_ff);

   always_comb begin
      count_in   = count_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      res_st_in  = res_st_ff;
      res_ent_in = res_ent_ff;
      if (cmd.decide) begin
         lo_in      = '0;
         hi_in      = count_ff;
         res_st_in  = dec_st;
         res_ent_in = dec_ent;
         if (wr_en) count_in = count_ff + CNT_W'(1);
      end
      if (cmd.compare) begin
         if (rd_data_ff.pos <= q_pos_ff) lo_in = mid + CNT_W'(1);
         else                            hi_in = mid;
      end
      if (cmd.capture) begin
         res_st_in  = ST_OK;
         res_ent_in = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_type_ff <= req_code_type'(req_type);
         q_pos_ff  <= req_position;
         q_ep_ff   <= req_epoch;
         q_w_ff    <= req_stripe_width;
      end
      if (cmd.decide && wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= wr_ent;
         last_ff                  <= wr_ent;
         if (empty) first_pos_ff <= wr_ent.pos;
      end
      if (cmd.rd_loop) rd_data_ff <= mem[rd_addr];
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      res_st_ff  <= res_st_in;
      res_ent_ff <= res_ent_in;
      if (cmd.emit) begin
         out_st_ff  <= res_st_ff;
         out_ent_ff <= res_ent_ff;
      end
   end

   assign rsp_status         = out_st_ff;
   assign rsp_entry_position = out_ent_ff.pos;
   assign rsp_entry_epoch    = out_ent_ff.ep;
   assign rsp_entry_width    = out_ent_ff.wid;

endmodule

// ===== sv/stripe_range_table.sv =====
// Top level of the stripe range table: controller plus datapath.
// Depends on srt_pkg, srt_ctrl and srt_dpath.
//
// One request is taken at a time and yields one response beat. Add, clone,
// read-latest and a find that fails its empty or below-first check go from
// the decide state straight to the done state. Any other find runs a binary
// search over the entry memory with one read and one compare per step. The
// single read port of the entry memory sets the search pace. The controller
// returns to idle as the response is loaded, and req_stall is high in every
// state but idle. A finished response waits in its output register while the
// next request is accepted.
module stripe_range_table
   import srt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_type,
   input  logic [POS_W-1:0] req_position,
   input  logic [EP_W-1:0]  req_epoch,
   input  logic [WID_W-1:0] req_stripe_width,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [ST_W-1:0]  rsp_status,
   output logic [POS_W-1:0] rsp_entry_position,
   output logic [EP_W-1:0]  rsp_entry_epoch,
   output logic [WID_W-1:0] rsp_entry_width
);

   cmd_type cmd;
   sts_type sts;

   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   srt_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_type           (req_type),
      .req_position       (req_position),
      .req_epoch          (req_epoch),
      .req_stripe_width   (req_stripe_width),
      .rsp_status         (rsp_status),
      .rsp_entry_position (rsp_entry_position),
      .rsp_entry_epoch    (rsp_entry_epoch),
      .rsp_entry_width    (rsp_entry_width)
   );

endmodule
